/* rtl/assert_macros.svh */
// Assertion macros shared by the frame parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property checked on the rising clock edge, ignored while reset is low.
`define HLFP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define HLFP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define HLFP_ASSERT(lbl, clk, rst_n, prop, msg)
`define HLFP_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

/* rtl/hlfp_pkg.sv */
// Types and constants of the header/length frame parser.
package hlfp_pkg;

    localparam int MAX_PAYLOAD_DEF = 128;
    localparam int BYTE_W          = 8;
    localparam int SUM_W           = 16;
    localparam int CFG_IDX_W       = 8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FIRST  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SECOND = 8'd1;

    localparam logic [BYTE_W-1:0] HEADER_FIRST_RST  = 8'h55;
    localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'hAA;

    // Result kinds
    localparam logic KIND_PAYLOAD   = 1'b0;
    localparam logic KIND_FRAME_END = 1'b1;

    typedef enum logic [2:0] {
        PH_HUNT1 = 3'd0,
        PH_HUNT2 = 3'd1,
        PH_LEN   = 3'd2,
        PH_ADDR  = 3'd3,
        PH_CMD   = 3'd4,
        PH_ARG   = 3'd5,
        PH_DATA  = 3'd6,
        PH_CSUM  = 3'd7
    } t_phase;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] payload_byte;
        logic [BYTE_W-1:0] payload_index;
        logic [BYTE_W-1:0] frame_addr;
        logic [BYTE_W-1:0] frame_cmd;
        logic [BYTE_W-1:0] frame_arg;
        logic [BYTE_W-1:0] payload_count;
        logic [SUM_W-1:0]  checksum_diff;
    } t_result;

endpackage

/* rtl/hlfp_parse.sv */
// Frame parser state machine: header hunt, field capture, running sum, checks.
module hlfp_parse
    import hlfp_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [BYTE_W-1:0] i_rx_byte,
    input  logic [BYTE_W-1:0] i_header_first,
    input  logic [BYTE_W-1:0] i_header_second,
    output logic              o_res_valid,
    output t_result           o_res
);

    localparam logic [BYTE_W-1:0] MaxPayload = BYTE_W'(MAX_PAYLOAD);

    t_phase            r_phase,    n_phase;
    logic [BYTE_W-1:0] r_count,    n_count;
    logic [SUM_W-1:0]  r_sum,      n_sum;
    logic [BYTE_W-1:0] r_len,      n_len;
    logic [BYTE_W-1:0] r_addr,     n_addr;
    logic [BYTE_W-1:0] r_cmd,      n_cmd;
    logic [BYTE_W-1:0] r_arg,      n_arg;
    logic [BYTE_W-1:0] r_csum_lo,  n_csum_lo;

    logic [BYTE_W-1:0] w_plen;
    logic [BYTE_W-1:0] w_next_cnt;
    logic [SUM_W-1:0]  w_sum_add;

    // Payload length: a length byte of two or less means no payload
    assign w_plen     = (r_len > BYTE_W'(2)) ? (r_len - BYTE_W'(2)) : '0;
    assign w_next_cnt = r_count + BYTE_W'(1);
    assign w_sum_add  = r_sum + {{(SUM_W-BYTE_W){1'b0}}, i_rx_byte};

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT1;
            r_count   <= '0;
            r_sum     <= '0;
            r_len     <= '0;
            r_addr    <= '0;
            r_cmd     <= '0;
            r_arg     <= '0;
            r_csum_lo <= '0;
        end else begin
            r_phase   <= n_phase;
            r_count   <= n_count;
            r_sum     <= n_sum;
            r_len     <= n_len;
            r_addr    <= n_addr;
            r_cmd     <= n_cmd;
            r_arg     <= n_arg;
            r_csum_lo <= n_csum_lo;
        end
    end

    // Next state and result for the byte in transfer
    always_comb begin
        n_phase   = r_phase;
        n_count   = r_count;
        n_sum     = r_sum;
        n_len     = r_len;
        n_addr    = r_addr;
        n_cmd     = r_cmd;
        n_arg     = r_arg;
        n_csum_lo = r_csum_lo;

        o_res_valid       = 1'b0;
        o_res             = '0;
        o_res.frame_addr  = r_addr;
        o_res.frame_cmd   = r_cmd;
        o_res.frame_arg   = r_arg;

        if (i_accept) begin
            unique case (r_phase)
                PH_HUNT1: begin
                    if (i_rx_byte == i_header_first) begin
                        n_phase = PH_HUNT2;
                    end
                end
                // a wrong second byte keeps us here
                PH_HUNT2: begin
                    if (i_rx_byte == i_header_second) begin
                        n_phase = PH_LEN;
                    end
                end
                PH_LEN: begin
                    n_len   = i_rx_byte;
                    n_sum   = {{(SUM_W-BYTE_W){1'b0}}, i_rx_byte};
                    n_phase = PH_ADDR;
                end
                PH_ADDR: begin
                    n_addr  = i_rx_byte;
                    n_sum   = w_sum_add;
                    n_phase = PH_CMD;
                end
                PH_CMD: begin
                    n_cmd   = i_rx_byte;
                    n_sum   = w_sum_add;
                    n_phase = PH_ARG;
                end
                PH_ARG: begin
                    n_arg   = i_rx_byte;
                    n_sum   = w_sum_add;
                    n_count = '0;
                    n_phase = (w_plen == '0) ? PH_CSUM : PH_DATA;
                end
                PH_DATA: begin
                    n_sum = w_sum_add;
                    // bytes past the limit are summed only
                    if (r_count < MaxPayload) begin
                        o_res_valid         = 1'b1;
                        o_res.kind          = KIND_PAYLOAD;
                        o_res.payload_byte  = i_rx_byte;
                        o_res.payload_index = r_count;
                    end
                    if (w_next_cnt >= w_plen) begin
                        n_count = '0;
                        n_phase = PH_CSUM;
                    end else begin
                        n_count = w_next_cnt;
                    end
                end
                PH_CSUM: begin
                    if (r_count == '0) begin
                        n_csum_lo = i_rx_byte;
                        n_count   = BYTE_W'(1);
                    end else begin
                        o_res_valid         = 1'b1;
                        o_res.kind          = KIND_FRAME_END;
                        o_res.payload_count = w_plen;
                        o_res.checksum_diff = ~r_sum - {i_rx_byte, r_csum_lo};
                        n_count             = '0;
                        n_phase             = PH_HUNT1;
                    end
                end
                default: begin
                    n_phase = PH_HUNT1;
                end
            endcase
        end
    end

endmodule

/* rtl/hlfp_obuf.sv */
// Output register and skid stage: bytes are taken under stall until the skid fills.
module hlfp_obuf
    import hlfp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_res_valid,
    input  t_result i_res,
    input  logic    i_stall,
    output logic    o_valid,
    output t_result o_res,
    output logic    o_full
);

    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;
    logic    w_out_xfer;

    assign w_out_xfer = r_out_valid && !i_stall;

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    // Skid drains first; a new result goes to the output when it frees up
    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            if (w_out_xfer) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (i_res_valid) begin
            if (!r_out_valid || w_out_xfer) begin
                n_out       = i_res;
                n_out_valid = 1'b1;
            end else begin
                n_skid       = i_res;
                n_skid_valid = 1'b1;
            end
        end else if (w_out_xfer) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;
    assign o_full  = r_skid_valid;

endmodule

/* rtl/header_length_frame_parser_core.sv */
// Top level of the header/length frame parser with its configuration registers.
// Usage:
//   Input channel: one received byte per transfer on i_rx_byte, i_in_valid,
//   o_in_stall. Output channel: one result per transfer on o_kind and the
//   field ports, o_out_valid, i_out_stall. Kind 0 is a payload byte with
//   its index, kind 1 ends a frame with address, command, argument, payload
//   count and checksum difference (zero means the frame is good).
//   Config channel: i_cfg_valid, o_cfg_ready (always high), i_cfg_index,
//   i_cfg_data; index 0 is the first sync byte, 1 the second, others ignored.
// Timing: a byte is taken every cycle while o_in_stall is low; its result,
//   if any, is registered in the output stage, or in the skid stage if the
//   output stalls. Parser throughput is one byte per clock when not stalled.
// Reset (synchronous, active low): sync bytes go to 0x55/0xAA, the parser
//   hunts for the first sync byte, and the output and skid stages empty.
// Stall: the output register holds its result; one more result fits in the
//   skid stage, and o_in_stall rises only while that stage is full.
module header_length_frame_parser_core
    import hlfp_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [BYTE_W-1:0]    i_rx_byte,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_kind,
    output logic [BYTE_W-1:0]    o_payload_byte,
    output logic [BYTE_W-1:0]    o_payload_index,
    output logic [BYTE_W-1:0]    o_frame_addr,
    output logic [BYTE_W-1:0]    o_frame_cmd,
    output logic [BYTE_W-1:0]    o_frame_arg,
    output logic [BYTE_W-1:0]    o_payload_count,
    output logic [SUM_W-1:0]     o_checksum_diff,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]    i_cfg_data
);

`include "assert_macros.svh"

    logic [BYTE_W-1:0] r_header_first;
    logic [BYTE_W-1:0] r_header_second;
    logic              w_in_accept;
    logic              w_res_valid;
    t_result           w_res;
    t_result           w_out;
    logic              w_full;

    assign o_cfg_ready = 1'b1;

    // Sync byte registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_first  <= HEADER_FIRST_RST;
            r_header_second <= HEADER_SECOND_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_HEADER_FIRST) begin
                r_header_first <= i_cfg_data;
            end
            if (i_cfg_index == CFG_HEADER_SECOND) begin
                r_header_second <= i_cfg_data;
            end
        end
    end

    assign o_in_stall  = w_full;
    assign w_in_accept = i_in_valid && !w_full;

    hlfp_parse #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parse (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (w_in_accept),
        .i_rx_byte       (i_rx_byte),
        .i_header_first  (r_header_first),
        .i_header_second (r_header_second),
        .o_res_valid     (w_res_valid),
        .o_res           (w_res)
    );

    hlfp_obuf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (w_res_valid),
        .i_res       (w_res),
        .i_stall     (i_out_stall),
        .o_valid     (o_out_valid),
        .o_res       (w_out),
        .o_full      (w_full)
    );

    assign o_kind          = w_out.kind;
    assign o_payload_byte  = w_out.payload_byte;
    assign o_payload_index = w_out.payload_index;
    assign o_frame_addr    = w_out.frame_addr;
    assign o_frame_cmd     = w_out.frame_cmd;
    assign o_frame_arg     = w_out.frame_arg;
    assign o_payload_count = w_out.payload_count;
    assign o_checksum_diff = w_out.checksum_diff;

    // Input stalls only when a result is held behind a full output register
    `HLFP_ASSERT(a_stall_needs_out, i_clk, i_rst_n, o_in_stall |-> o_out_valid, "input stalled with empty output")

    // Payload results carry no frame-end summary
    `HLFP_ASSERT(a_payload_clean, i_clk, i_rst_n, (o_out_valid && o_kind == KIND_PAYLOAD) |-> (o_payload_count == '0 && o_checksum_diff == '0), "payload result with summary fields")

    // Reset empties both output stages
    `HLFP_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> (!o_out_valid && !o_in_stall), "output not empty after reset")

endmodule

/* sim/tb_header_length_frame_parser_core.sv */
// Self-checking testbench for the header/length frame parser core.
module tb_header_length_frame_parser_core;
    timeunit 1ns;
    timeprecision 1ps;
    import hlfp_pkg::*;

    localparam int BODY_LIMIT   = MAX_PAYLOAD_DEF;
    localparam int DRAIN_CYCLES = 8;
    localparam int LIMIT_NS     = 2_000_000;

    // Register indexes past the two sync bytes; writes there are dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_NEXT = CFG_HEADER_SECOND + 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LAST = '1;

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 in_valid   = 1'b0;
    logic [BYTE_W-1:0]    rx_byte    = '0;
    logic                 out_stall  = 1'b0;
    logic                 cfg_valid  = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index  = '0;
    logic [BYTE_W-1:0]    cfg_data   = '0;

    logic                 o_in_stall;
    logic                 o_out_valid;
    logic                 o_kind;
    logic [BYTE_W-1:0]    o_payload_byte;
    logic [BYTE_W-1:0]    o_payload_index;
    logic [BYTE_W-1:0]    o_frame_addr;
    logic [BYTE_W-1:0]    o_frame_cmd;
    logic [BYTE_W-1:0]    o_frame_arg;
    logic [BYTE_W-1:0]    o_payload_count;
    logic [SUM_W-1:0]     o_checksum_diff;
    logic                 o_cfg_ready;

    // Idle rates in percent of cycles
    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int fail_count      = 0;
    int bytes_sent      = 0;

    // Parser shadow state, updated on every accepted byte
    t_phase            p_phase    = PH_HUNT1;
    logic [BYTE_W-1:0] p_count    = '0;
    logic [SUM_W-1:0]  p_sum      = '0;
    logic [BYTE_W-1:0] p_len      = '0;
    logic [BYTE_W-1:0] p_addr     = '0;
    logic [BYTE_W-1:0] p_cmd      = '0;
    logic [BYTE_W-1:0] p_arg      = '0;
    logic [BYTE_W-1:0] p_csum_lo  = '0;
    logic [BYTE_W-1:0] hdr_first  = HEADER_FIRST_RST;
    logic [BYTE_W-1:0] hdr_second = HEADER_SECOND_RST;

    t_result parsed_results[$];

    header_length_frame_parser_core #(
        .MAX_PAYLOAD(BODY_LIMIT)
    ) dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (o_in_stall),
        .i_rx_byte      (rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (out_stall),
        .o_kind         (o_kind),
        .o_payload_byte (o_payload_byte),
        .o_payload_index(o_payload_index),
        .o_frame_addr   (o_frame_addr),
        .o_frame_cmd    (o_frame_cmd),
        .o_frame_arg    (o_frame_arg),
        .o_payload_count(o_payload_count),
        .o_checksum_diff(o_checksum_diff),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // Payload bytes between argument and checksum; short lengths mean none
    function automatic logic [BYTE_W-1:0] body_len();
        return (p_len > 8'd2) ? p_len - 8'd2 : 8'd0;
    endfunction

    // Advance the shadow parser by one byte and queue any result it gives
    task automatic parse_byte(input logic [BYTE_W-1:0] b);
        t_result          r;
        logic [SUM_W-1:0] rx_sum;
        bit               emit;
        r    = '0;
        emit = 1'b0;
        case (p_phase)
            PH_HUNT1: if (b == hdr_first) p_phase = PH_HUNT2;
            // a wrong second sync byte keeps the parser here
            PH_HUNT2: if (b == hdr_second) p_phase = PH_LEN;
            PH_LEN: begin
                p_len   = b;
                p_sum   = {8'h00, b};
                p_phase = PH_ADDR;
            end
            PH_ADDR: begin
                p_addr  = b;
                p_sum   = p_sum + b;
                p_phase = PH_CMD;
            end
            PH_CMD: begin
                p_cmd   = b;
                p_sum   = p_sum + b;
                p_phase = PH_ARG;
            end
            PH_ARG: begin
                p_arg   = b;
                p_sum   = p_sum + b;
                p_count = '0;
                p_phase = (body_len() == 8'd0) ? PH_CSUM : PH_DATA;
            end
            PH_DATA: begin
                p_sum = p_sum + b;
                // bytes past the limit still count in the sum
                if (p_count < BODY_LIMIT) begin
                    r.kind          = KIND_PAYLOAD;
                    r.payload_byte  = b;
                    r.payload_index = p_count;
                    emit            = 1'b1;
                end
                p_count = p_count + 8'd1;
                if (p_count >= body_len()) begin
                    p_count = '0;
                    p_phase = PH_CSUM;
                end
            end
            PH_CSUM: begin
                if (p_count == 8'd0) begin
                    p_csum_lo = b;
                    p_count   = 8'd1;
                end else begin
                    rx_sum          = {b, p_csum_lo};
                    r.kind          = KIND_FRAME_END;
                    r.payload_count = body_len();
                    r.checksum_diff = ~p_sum - rx_sum;
                    emit            = 1'b1;
                    p_count         = '0;
                    p_phase         = PH_HUNT1;
                end
            end
        endcase
        if (emit) begin
            r.frame_addr = p_addr;
            r.frame_cmd  = p_cmd;
            r.frame_arg  = p_arg;
            parsed_results.push_back(r);
        end
    endtask

    task automatic check_field(input string name, input logic [SUM_W-1:0] want,
                               input logic [SUM_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // Receiver: random stall and result checking on each output transfer
    always @(posedge clk) begin
        t_result want;
        if (rst_n && o_out_valid && !out_stall) begin
            if (parsed_results.size() == 0) begin
                $error("result transfer with nothing outstanding");
                fail_count++;
            end else begin
                want = parsed_results.pop_front();
                check_field("kind", want.kind, o_kind);
                check_field("payload_byte", want.payload_byte, o_payload_byte);
                check_field("payload_index", want.payload_index, o_payload_index);
                check_field("frame_addr", want.frame_addr, o_frame_addr);
                check_field("frame_cmd", want.frame_cmd, o_frame_cmd);
                check_field("frame_arg", want.frame_arg, o_frame_arg);
                check_field("payload_count", want.payload_count, o_payload_count);
                check_field("checksum_diff", want.checksum_diff, o_checksum_diff);
            end
        end
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // One byte transfer, after a random idle gap; valid is left high
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct) gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (o_in_stall);
        bytes_sent++;
        parse_byte(b);
    endtask

    // Drop valid, wait for every outstanding result and let the pipe empty
    task automatic settle();
        in_valid <= 1'b0;
        while (parsed_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_HEADER_FIRST) hdr_first = data;
        else if (idx == CFG_HEADER_SECOND) hdr_second = data;
    endtask

    // Build a frame for the current sync bytes; keep < 0 sends all of it
    task automatic send_frame(input logic [BYTE_W-1:0] len, input logic [BYTE_W-1:0] addr,
                              input logic [BYTE_W-1:0] cmd, input logic [BYTE_W-1:0] arg,
                              input bit good_sum, input bit bad_second,
                              input bit extreme_body, input int keep);
        logic [BYTE_W-1:0] seq[$];
        logic [SUM_W-1:0]  sum;
        logic [SUM_W-1:0]  csum;
        logic [BYTE_W-1:0] pb;
        int                n_body;
        seq.push_back(hdr_first);
        if (bad_second) seq.push_back(~hdr_second);
        seq.push_back(hdr_second);
        seq.push_back(len);
        seq.push_back(addr);
        seq.push_back(cmd);
        seq.push_back(arg);
        sum    = len + addr + cmd + arg;
        n_body = (len > 8'd2) ? len - 2 : 0;
        for (int k = 0; k < n_body; k++) begin
            pb  = extreme_body ? ((k % 2) ? 8'hFF : 8'h00) : 8'($urandom_range(255));
            sum = sum + pb;
            seq.push_back(pb);
        end
        csum = good_sum ? ~sum : 16'($urandom);
        seq.push_back(csum[7:0]);
        seq.push_back(csum[15:8]);
        if (keep < 0 || keep > seq.size()) keep = seq.size();
        for (int k = 0; k < keep; k++) send_byte(seq[k]);
    endtask

    // Mostly whole frames of small size, some noise and cut-off frames
    task automatic run_traffic(input int n_bytes);
        int start;
        int pick;
        logic [BYTE_W-1:0] len;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes) begin
            pick = $urandom_range(99);
            if ($urandom_range(99) < 2) len = 8'($urandom_range(128, 255));
            else if ($urandom_range(99) < 10) len = 8'($urandom_range(13, 40));
            else len = 8'($urandom_range(0, 12));
            if (pick < 10) begin
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(255)));
            end else if (pick < 20) begin
                send_frame(len, 8'($urandom), 8'($urandom), 8'($urandom), 1'b1, 1'b0, 1'b0,
                           $urandom_range(1, 9));
            end else begin
                send_frame(len, 8'($urandom), 8'($urandom), 8'($urandom),
                           $urandom_range(99) < 75, $urandom_range(99) < 10, 1'b0, -1);
            end
        end
    endtask

    // Reset sync bytes: wrong second byte, short lengths, field extremes
    task automatic test_default_sync_frames();
        send_frame(8'd0, 8'hFF, 8'h00, 8'hFF, 1'b1, 1'b1, 1'b0, -1);
        send_frame(8'd4, 8'h00, 8'hFF, 8'h00, 1'b0, 1'b0, 1'b1, -1);
        send_frame(8'd2, 8'h5A, 8'hA5, 8'h01, 1'b1, 1'b0, 1'b0, -1);
        settle();
    endtask

    // Largest length: bytes past the emit limit only feed the sum
    task automatic test_long_payload();
        send_frame(8'hFF, 8'($urandom), 8'($urandom), 8'($urandom), 1'b1, 1'b0, 1'b0, -1);
        settle();
    endtask

    // Sync byte extremes, equal sync bytes and writes to unused indexes
    task automatic test_sync_byte_settings();
        write_reg(CFG_HEADER_FIRST, 8'h00);
        write_reg(CFG_HEADER_SECOND, 8'hFF);
        run_traffic(15);
        settle();
        write_reg(CFG_HEADER_FIRST, 8'hFF);
        write_reg(CFG_HEADER_SECOND, 8'h00);
        run_traffic(15);
        settle();
        write_reg(CFG_HEADER_FIRST, 8'h3C);
        write_reg(CFG_HEADER_SECOND, 8'h3C);
        run_traffic(15);
        settle();
        write_reg(CFG_UNUSED_NEXT, 8'h00);
        write_reg(CFG_UNUSED_LAST, 8'hFF);
        run_traffic(15);
        settle();
    endtask

    // Random sync bytes under each idle pattern of sender and receiver
    task automatic test_idle_patterns();
        int send_pct[4]  = '{0, 53, 0, 20};
        int stall_pct[4] = '{0, 0, 53, 20};
        for (int m = 0; m < 4; m++) begin
            write_reg(CFG_HEADER_FIRST, 8'($urandom));
            write_reg(CFG_HEADER_SECOND, 8'($urandom));
            sender_idle_pct = send_pct[m];
            recv_stall_pct  = stall_pct[m];
            run_traffic(30);
            settle();
        end
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_sync_frames();
        test_long_payload();
        test_sync_byte_settings();
        test_idle_patterns();
        settle();
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Hang guard
    initial begin
        #(LIMIT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
